FILE: sv/hlcm_pkg.sv
// Shared constants, types and helper functions for the Hough line cluster table.
`default_nettype none

package hlcm_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int OP_W      = 2;
    localparam int RHO_IN_W  = 16;
    localparam int TH_IN_W   = 18;
    localparam int INV_W     = 24;
    localparam int Q_W       = 19;
    localparam int TH_N_W    = 18;
    localparam int STATUS_W  = 3;
    localparam int ENTRY_W   = 6;
    localparam int MC_W      = 7;

    localparam int MAG_W     = RHO_IN_W + 1;
    localparam int RPROD_W   = MAG_W + INV_W;
    localparam int RSUM_W    = RPROD_W + 1;
    localparam int R_SHIFT   = 12;
    localparam int PM_W      = RSUM_W - R_SHIFT;
    localparam int INVPI_W   = 23;
    localparam int TPROD_W   = TH_IN_W + INVPI_W;
    localparam int TSUM_W    = TPROD_W + 1;
    localparam int T_SHIFT   = 24;
    localparam int SQR_W     = 2 * (Q_W + 1);
    localparam int SQT_W     = 2 * (Q_W + 2);
    localparam int D2_W      = SQT_W + 1;

    localparam logic [INV_W-1:0]   INV_RESET  = INV_W'(26214);
    localparam logic [INVPI_W-1:0] INV_PI_Q24 = INVPI_W'(5340354);
    localparam logic [RSUM_W-1:0]  R_ROUND    = RSUM_W'(2048);
    localparam logic [TSUM_W-1:0]  T_ROUND    = TSUM_W'(8388608);
    localparam logic [D2_W-1:0]    REACH_SQ   = D2_W'(966368);

    localparam int WRAP_HIGH        = 63716;
    localparam int WRAP_LOW         = 1820;
    localparam int SHIFT_DOWN_ABOVE = 49152;
    localparam int SHIFT_UP_BELOW   = 16384;
    localparam int ONE_TURN         = 65536;

    localparam logic signed [Q_W-1:0] Q_MAX_V = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN_V = {1'b1, {(Q_W-1){1'b0}}};

    localparam logic [OP_W-1:0] OP_CLEAR  = OP_W'(0);
    localparam logic [OP_W-1:0] OP_INSERT = OP_W'(1);
    localparam logic [OP_W-1:0] OP_READ   = OP_W'(2);

    localparam logic [STATUS_W-1:0] ST_CLEARED  = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_APPENDED = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_MERGED   = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] ST_DROPPED  = STATUS_W'(3);
    localparam logic [STATUS_W-1:0] ST_ENTRY    = STATUS_W'(4);
    localparam logic [STATUS_W-1:0] ST_EMPTY    = STATUS_W'(5);

    typedef enum logic [1:0] {
        RES_CLEARED,
        RES_INSERT,
        RES_ENTRY,
        RES_EMPTY
    } res_kind_t;

    typedef struct packed {
        logic             take;
        logic             norm1;
        logic             norm2;
        logic             scan_issue;
        logic             rd_issue;
        logic [IDX_W-1:0] addr;
        logic             load;
        res_kind_t        kind;
        logic             last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [CNT_W-1:0] count;
        logic             out_free;
    } ctrl_stat_t;

    function automatic logic [Q_W-1:0] mag_q(input logic signed [Q_W-1:0] v);
        logic signed [Q_W:0] w;
        w = {v[Q_W-1], v};
        return v[Q_W-1] ? Q_W'(-w) : Q_W'(w);
    endfunction

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [Q_W:0] v);
        logic signed [Q_W:0] hi;
        logic signed [Q_W:0] lo;
        hi = {Q_MAX_V[Q_W-1], Q_MAX_V};
        lo = {Q_MIN_V[Q_W-1], Q_MIN_V};
        if (v > hi)
            return Q_MAX_V;
        else if (v < lo)
            return Q_MIN_V;
        else
            return Q_W'(v);
    endfunction

endpackage

`default_nettype wire

FILE: sv/hlcm_ctrl.sv
// Controller state machine that sequences clear, insert and read out operations.
`default_nettype none

module hlcm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire hlcm_pkg::ctrl_stat_t stat,
    output hlcm_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_EMPTY,
        S_NORM1,
        S_NORM2,
        S_SCAN,
        S_WAIT,
        S_FINISH,
        S_RD_ISSUE,
        S_RD_EMIT
    } state_t;

    state_t                      state_reg;
    logic [hlcm_pkg::CNT_W-1:0]  idx_reg;
    logic [hlcm_pkg::CNT_W-1:0]  idx_inc;
    logic                        rd_last;

    assign idx_inc  = idx_reg + hlcm_pkg::CNT_W'(1);
    assign rd_last  = (idx_inc == stat.count);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.addr       = idx_reg[hlcm_pkg::IDX_W-1:0];
        cmd.kind       = hlcm_pkg::RES_INSERT;
        cmd.last       = 1'b1;
        case (state_reg)
            S_IDLE:     cmd.take = in_valid;
            S_NORM1:    cmd.norm1 = 1'b1;
            S_NORM2:    cmd.norm2 = 1'b1;
            S_SCAN:     cmd.scan_issue = (idx_reg < stat.count);
            S_RD_ISSUE: cmd.rd_issue = 1'b1;
            S_RD_EMIT:
            begin
                cmd.load = stat.out_free;
                cmd.kind = hlcm_pkg::RES_ENTRY;
                cmd.last = rd_last;
            end
            S_CLEAR:
            begin
                cmd.load = stat.out_free;
                cmd.kind = hlcm_pkg::RES_CLEARED;
            end
            S_EMPTY:
            begin
                cmd.load = stat.out_free;
                cmd.kind = hlcm_pkg::RES_EMPTY;
            end
            S_FINISH:
            begin
                cmd.load = stat.out_free;
                cmd.kind = hlcm_pkg::RES_INSERT;
            end
            default:    cmd.take = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (in_valid)
                    begin
                        case (stat.opcode)
                            hlcm_pkg::OP_CLEAR:  state_reg <= S_CLEAR;
                            hlcm_pkg::OP_INSERT: state_reg <= S_NORM1;
                            hlcm_pkg::OP_READ:
                                state_reg <= (stat.count == '0) ? S_EMPTY : S_RD_ISSUE;
                            default:             state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_NORM1: state_reg <= S_NORM2;
                S_NORM2: state_reg <= S_SCAN;
                S_SCAN:
                begin
                    if (idx_reg < stat.count)
                        idx_reg <= idx_inc;
                    else
                        state_reg <= S_WAIT;
                end
                S_WAIT: state_reg <= S_FINISH;
                S_RD_ISSUE: state_reg <= S_RD_EMIT;
                S_RD_EMIT:
                begin
                    if (stat.out_free)
                    begin
                        if (rd_last)
                            state_reg <= S_IDLE;
                        else
                        begin
                            idx_reg   <= idx_inc;
                            state_reg <= S_RD_ISSUE;
                        end
                    end
                end
                S_CLEAR, S_EMPTY, S_FINISH:
                begin
                    if (stat.out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/hlcm_datapath.sv
// Datapath with normalization, cluster table, distance pipeline and output register.
`default_nettype none

module hlcm_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire hlcm_pkg::ctrl_cmd_t                   cmd,
    output hlcm_pkg::ctrl_stat_t                       stat,
    input  wire logic [hlcm_pkg::OP_W-1:0]             opcode,
    input  wire logic signed [hlcm_pkg::RHO_IN_W-1:0]  line_rho,
    input  wire logic [hlcm_pkg::TH_IN_W-1:0]          line_theta,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [hlcm_pkg::INV_W-1:0]            inv_image_width,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [hlcm_pkg::STATUS_W-1:0]              status,
    output logic [hlcm_pkg::ENTRY_W-1:0]               entry_index,
    output logic signed [hlcm_pkg::Q_W-1:0]            cluster_rho,
    output logic signed [hlcm_pkg::Q_W-1:0]            cluster_theta,
    output logic [hlcm_pkg::MC_W-1:0]                  merge_count,
    output logic                                       last
);

    localparam int Q_W = hlcm_pkg::Q_W;

    logic [hlcm_pkg::INV_W-1:0]           inv_reg;
    logic signed [hlcm_pkg::RHO_IN_W-1:0] rho_in_reg;
    logic [hlcm_pkg::TH_IN_W-1:0]         theta_in_reg;

    logic                                 neg_reg;
    logic [hlcm_pkg::RPROD_W-1:0]         rprod_reg;
    logic [hlcm_pkg::TPROD_W-1:0]         tprod_reg;

    logic signed [Q_W-1:0]                trho_reg;
    logic [hlcm_pkg::TH_N_W-1:0]          tth_reg;
    logic                                 wrap_fwd_reg;
    logic                                 wrap_rev_reg;

    logic signed [Q_W-1:0]                mem_rho   [hlcm_pkg::TABLE_DEPTH];
    logic signed [Q_W-1:0]                mem_theta [hlcm_pkg::TABLE_DEPTH];
    logic signed [Q_W-1:0]                rd_rho_reg;
    logic signed [Q_W-1:0]                rd_theta_reg;

    logic                                 s1_valid_reg;
    logic [hlcm_pkg::IDX_W-1:0]           s1_idx_reg;
    logic                                 s2_valid_reg;
    logic [hlcm_pkg::IDX_W-1:0]           s2_idx_reg;
    logic signed [Q_W-1:0]                s2_orho_reg;
    logic signed [Q_W:0]                  s2_oth_reg;
    logic [hlcm_pkg::SQR_W-1:0]           s2_sqr_reg;
    logic [hlcm_pkg::SQT_W-1:0]           s2_sqt_reg;

    logic [hlcm_pkg::MC_W-1:0]            merged_reg;
    logic [hlcm_pkg::CNT_W-1:0]           count_reg;

    logic                                 out_valid_reg;
    logic [hlcm_pkg::STATUS_W-1:0]        status_reg;
    logic [hlcm_pkg::ENTRY_W-1:0]         entry_reg;
    logic signed [Q_W-1:0]                orho_out_reg;
    logic signed [Q_W-1:0]                oth_out_reg;
    logic [hlcm_pkg::MC_W-1:0]            mc_reg;
    logic                                 last_reg;

    logic [hlcm_pkg::MAG_W-1:0]           mag;
    logic signed [hlcm_pkg::MAG_W-1:0]    rho_ext;
    logic [hlcm_pkg::RSUM_W-1:0]          rsum;
    logic [hlcm_pkg::PM_W-1:0]            pm;
    logic [hlcm_pkg::TSUM_W-1:0]          tsum;
    logic [hlcm_pkg::TH_N_W-1:0]          tth_next;
    logic signed [Q_W-1:0]                trho_next;

    logic [Q_W-1:0]                       abs_t;
    logic [Q_W-1:0]                       abs_o1;
    logic signed [Q_W:0]                  oth1;
    logic signed [Q_W:0]                  dr;
    logic signed [Q_W+1:0]                dt;
    logic signed [hlcm_pkg::SQR_W-1:0]    sqr;
    logic signed [hlcm_pkg::SQT_W-1:0]    sqt;

    logic [hlcm_pkg::D2_W-1:0]            d2;
    logic                                 hit;
    logic [Q_W-1:0]                       abs_o2;
    logic signed [Q_W:0]                  sum_neg;
    logic [Q_W:0]                         sum_abs;
    logic signed [Q_W-1:0]                avg_rho;
    logic signed [Q_W+1:0]                sum_th;
    logic signed [Q_W-1:0]                avg_theta;

    logic                                 insert_done;
    logic                                 append;
    logic                                 table_full;
    logic                                 wr_en;
    logic [hlcm_pkg::IDX_W-1:0]           wr_addr;
    logic signed [Q_W-1:0]                wr_rho;
    logic signed [Q_W-1:0]                wr_theta;
    logic                                 rd_en;

    assign cfg_ready     = 1'b1;
    assign stat.opcode   = opcode;
    assign stat.count    = count_reg;
    assign stat.out_free = !out_valid_reg || !out_stall;

    // Normalization.
    assign rho_ext  = {rho_in_reg[hlcm_pkg::RHO_IN_W-1], rho_in_reg};
    assign mag      = rho_in_reg[hlcm_pkg::RHO_IN_W-1] ? hlcm_pkg::MAG_W'(-rho_ext)
                                                       : hlcm_pkg::MAG_W'(rho_ext);
    assign rsum     = hlcm_pkg::RSUM_W'(rprod_reg) + hlcm_pkg::R_ROUND;
    assign pm       = rsum[hlcm_pkg::RSUM_W-1:hlcm_pkg::R_SHIFT];
    assign tsum     = hlcm_pkg::TSUM_W'(tprod_reg) + hlcm_pkg::T_ROUND;
    assign tth_next = tsum[hlcm_pkg::T_SHIFT +: hlcm_pkg::TH_N_W];

    always_comb
    begin
        if (neg_reg)
        begin
            if (pm > hlcm_pkg::PM_W'(hlcm_pkg::Q_MAX_V) + hlcm_pkg::PM_W'(1))
                trho_next = hlcm_pkg::Q_MIN_V;
            else
                trho_next = Q_W'(hlcm_pkg::PM_W'(0) - pm);
        end
        else
        begin
            if (pm > hlcm_pkg::PM_W'(hlcm_pkg::Q_MAX_V))
                trho_next = hlcm_pkg::Q_MAX_V;
            else
                trho_next = Q_W'(pm);
        end
    end

    // Compare stage one: shifted theta and squared differences.
    assign abs_t  = hlcm_pkg::mag_q(trho_reg);
    assign abs_o1 = hlcm_pkg::mag_q(rd_rho_reg);

    always_comb
    begin
        oth1 = {rd_theta_reg[Q_W-1], rd_theta_reg};
        if (wrap_rev_reg && (rd_theta_reg > hlcm_pkg::SHIFT_DOWN_ABOVE))
            oth1 = oth1 - (Q_W+1)'(hlcm_pkg::ONE_TURN);
        if (wrap_fwd_reg && (rd_theta_reg < hlcm_pkg::SHIFT_UP_BELOW))
            oth1 = oth1 + (Q_W+1)'(hlcm_pkg::ONE_TURN);
    end

    assign dr  = $signed({1'b0, abs_t}) - $signed({1'b0, abs_o1});
    assign dt  = $signed({{(Q_W+2-hlcm_pkg::TH_N_W){1'b0}}, tth_reg})
               - $signed({oth1[Q_W], oth1});
    assign sqr = dr * dr;
    assign sqt = dt * dt;

    // Compare stage two: reach test and averages.
    assign d2  = hlcm_pkg::D2_W'(s2_sqr_reg) + hlcm_pkg::D2_W'(s2_sqt_reg);
    assign hit = s2_valid_reg && (d2 < hlcm_pkg::REACH_SQ);

    assign abs_o2  = hlcm_pkg::mag_q(s2_orho_reg);
    assign sum_neg = $signed({trho_reg[Q_W-1], trho_reg})
                   + $signed({s2_orho_reg[Q_W-1], s2_orho_reg});
    assign sum_abs = {1'b0, abs_t} + {1'b0, abs_o2};
    assign sum_th  = $signed({{(Q_W+2-hlcm_pkg::TH_N_W){1'b0}}, tth_reg})
                   + $signed({s2_oth_reg[Q_W], s2_oth_reg});

    always_comb
    begin
        if (trho_reg[Q_W-1] && s2_orho_reg[Q_W-1])
            avg_rho = sum_neg[Q_W:1];
        else
            avg_rho = hlcm_pkg::sat_q($signed({1'b0, sum_abs[Q_W:1]}));
        avg_theta = hlcm_pkg::sat_q(sum_th[Q_W+1:1]);
    end

    assign insert_done = cmd.load && (cmd.kind == hlcm_pkg::RES_INSERT);
    assign table_full  = (count_reg >= hlcm_pkg::CNT_W'(hlcm_pkg::TABLE_DEPTH));
    assign append      = insert_done && (merged_reg == '0) && !table_full;

    always_comb
    begin
        wr_en    = hit || append;
        wr_addr  = s2_idx_reg;
        wr_rho   = avg_rho;
        wr_theta = avg_theta;
        if (append)
        begin
            wr_addr  = count_reg[hlcm_pkg::IDX_W-1:0];
            wr_rho   = trho_reg;
            wr_theta = {1'b0, tth_reg};
        end
    end

    assign rd_en = cmd.scan_issue || cmd.rd_issue;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_rho[wr_addr]   <= wr_rho;
            mem_theta[wr_addr] <= wr_theta;
        end
        if (rd_en)
        begin
            rd_rho_reg   <= mem_rho[cmd.addr];
            rd_theta_reg <= mem_theta[cmd.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            rho_in_reg   <= line_rho;
            theta_in_reg <= line_theta;
        end
        if (cmd.norm1)
        begin
            neg_reg   <= rho_in_reg[hlcm_pkg::RHO_IN_W-1];
            rprod_reg <= hlcm_pkg::RPROD_W'(mag) * hlcm_pkg::RPROD_W'(inv_reg);
            tprod_reg <= hlcm_pkg::TPROD_W'(theta_in_reg)
                       * hlcm_pkg::TPROD_W'(hlcm_pkg::INV_PI_Q24);
        end
        if (cmd.norm2)
        begin
            trho_reg     <= trho_next;
            tth_reg      <= tth_next;
            wrap_fwd_reg <= (tth_next >= hlcm_pkg::TH_N_W'(hlcm_pkg::WRAP_HIGH));
            wrap_rev_reg <= (tth_next <= hlcm_pkg::TH_N_W'(hlcm_pkg::WRAP_LOW));
        end
        s1_idx_reg  <= cmd.addr;
        s2_idx_reg  <= s1_idx_reg;
        s2_orho_reg <= rd_rho_reg;
        s2_oth_reg  <= oth1;
        s2_sqr_reg  <= unsigned'(sqr);
        s2_sqt_reg  <= unsigned'(sqt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg       <= hlcm_pkg::INV_RESET;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            merged_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                inv_reg <= inv_image_width;
            s1_valid_reg <= cmd.scan_issue;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.take)
                merged_reg <= '0;
            else if (hit)
                merged_reg <= merged_reg + hlcm_pkg::MC_W'(1);
            if (cmd.load && (cmd.kind == hlcm_pkg::RES_CLEARED))
                count_reg <= '0;
            else if (append)
                count_reg <= count_reg + hlcm_pkg::CNT_W'(1);
            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            last_reg <= cmd.last;
            case (cmd.kind)
                hlcm_pkg::RES_CLEARED:
                begin
                    status_reg   <= hlcm_pkg::ST_CLEARED;
                    entry_reg    <= '0;
                    orho_out_reg <= '0;
                    oth_out_reg  <= '0;
                    mc_reg       <= '0;
                end
                hlcm_pkg::RES_EMPTY:
                begin
                    status_reg   <= hlcm_pkg::ST_EMPTY;
                    entry_reg    <= '0;
                    orho_out_reg <= '0;
                    oth_out_reg  <= '0;
                    mc_reg       <= '0;
                end
                hlcm_pkg::RES_ENTRY:
                begin
                    status_reg   <= hlcm_pkg::ST_ENTRY;
                    entry_reg    <= hlcm_pkg::ENTRY_W'(cmd.addr);
                    orho_out_reg <= rd_rho_reg;
                    oth_out_reg  <= rd_theta_reg;
                    mc_reg       <= '0;
                end
                default:
                begin
                    if (merged_reg != '0)
                        status_reg <= hlcm_pkg::ST_MERGED;
                    else if (!table_full)
                        status_reg <= hlcm_pkg::ST_APPENDED;
                    else
                        status_reg <= hlcm_pkg::ST_DROPPED;
                    entry_reg    <= append ? hlcm_pkg::ENTRY_W'(count_reg) : '0;
                    orho_out_reg <= trho_reg;
                    oth_out_reg  <= {1'b0, tth_reg};
                    mc_reg       <= merged_reg;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign entry_index   = entry_reg;
    assign cluster_rho   = orho_out_reg;
    assign cluster_theta = oth_out_reg;
    assign merge_count   = mc_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

FILE: sv/hough_line_cluster_merge_core.sv
// Top level of the Hough line cluster table: controller plus datapath.
// An insert normalizes the line (NORM1, NORM2), scans the stored clusters one entry per cycle
// through the compare pipeline over the table memory's single read port, then emits its word.
// A read out issues a table read and emits that entry for each stored cluster in turn; clear and
// empty give a single word. One operation is in flight at a time; the next input is taken once
// the controller is back in idle. Reset empties the table, sets inv_image_width to 26214.
`default_nettype none

module hough_line_cluster_merge_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [hlcm_pkg::OP_W-1:0]             opcode,
    input  wire logic signed [hlcm_pkg::RHO_IN_W-1:0]  line_rho,
    input  wire logic [hlcm_pkg::TH_IN_W-1:0]          line_theta,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [hlcm_pkg::INV_W-1:0]            inv_image_width,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [hlcm_pkg::STATUS_W-1:0]              status,
    output logic [hlcm_pkg::ENTRY_W-1:0]               entry_index,
    output logic signed [hlcm_pkg::Q_W-1:0]            cluster_rho,
    output logic signed [hlcm_pkg::Q_W-1:0]            cluster_theta,
    output logic [hlcm_pkg::MC_W-1:0]                  merge_count,
    output logic                                       last
);

    hlcm_pkg::ctrl_cmd_t  cmd;
    hlcm_pkg::ctrl_stat_t stat;

    hlcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    hlcm_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .opcode          (opcode),
        .line_rho        (line_rho),
        .line_theta      (line_theta),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .inv_image_width (inv_image_width),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .entry_index     (entry_index),
        .cluster_rho     (cluster_rho),
        .cluster_theta   (cluster_theta),
        .merge_count     (merge_count),
        .last            (last)
    );

endmodule

`default_nettype wire
